// ----- hw/rtl/suki_pkg.sv -----
package suki_pkg;

    localparam int KEY_W       = 27;
    localparam int LETTER_W    = 8;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int ENTRY_CNT_W = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DUP      = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]    id_key;
        logic [LETTER_W-1:0] check_letter;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic load_prev;
        logic load_new;
    } cell_ctrl_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cell_flag_t;

endpackage

// ----- hw/rtl/suki_req_if.sv -----
interface suki_req_if;
    import suki_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    id_key;
    logic [LETTER_W-1:0] check_letter;

    modport source (output valid, output id_key, output check_letter, input ready);
    modport sink   (input valid, input id_key, input check_letter, output ready);
endinterface

// ----- hw/rtl/suki_rsp_if.sv -----
interface suki_rsp_if;
    import suki_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [POS_W-1:0]       position;
    logic [ENTRY_CNT_W-1:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

// ----- hw/rtl/sorted_unique_key_insert.sv -----
// Sorted table of up to CAPACITY entries (27-bit key, 8-bit letter), kept in
// ascending key order in a row of CAPACITY cells. In the cycle that a word
// is taken, every cell compares its key with the incoming one; the next
// cycle commits it, or later if the previous result still waits in the
// output register: the table is checked for full and duplicate, the
// insertion slot is found from the neighbor compare flags, and cells at and
// above it shift up one place while the new entry is written. Each word
// passes a compare step and then a commit step over the cell row, and the
// next word is taken once the commit is done, even while the result still
// waits in the output register. No reset pass is needed.
module sorted_unique_key_insert #(
    parameter int CAPACITY = 16
) (
    input logic       clk,
    input logic       rst_n,
    suki_req_if.sink   req,
    suki_rsp_if.source rsp
);
    import suki_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                   cmp_valid_reg;
    logic                   cmp_valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    entry_t                 hold_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    status_t                status_reg;
    status_t                status_next;
    logic [POS_W-1:0]       position_reg;
    logic [POS_W-1:0]       position_next;
    logic [ENTRY_CNT_W-1:0] entry_count_reg;
    logic [ENTRY_CNT_W-1:0] entry_count_next;

    logic                   accept;
    logic                   commit;
    logic                   full;
    logic                   dup;
    logic                   insert;
    logic [IDX_W-1:0]       slot_idx;
    entry_t                 probe_entry;

    entry_t                 cell_entry [CAPACITY];
    cell_flag_t             cell_flag  [CAPACITY];
    logic [CAPACITY-1:0]    eq_vec;
    logic [CAPACITY-1:0]    ins_vec;

    assign accept = req.valid && req.ready;
    assign commit = cmp_valid_reg && (!rsp_valid_reg || rsp.ready);

    assign probe_entry.id_key       = req.id_key;
    assign probe_entry.check_letter = req.check_letter;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign dup    = |eq_vec;
    assign insert = !full && !dup;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            logic       prev_gt;
            entry_t     prev_entry;

            if (gi == 0)
            begin : g_first
                assign prev_gt    = 1'b0;
                assign prev_entry = hold_reg;
            end
            else
            begin : g_rest
                assign prev_gt    = cell_flag[gi-1].gt;
                assign prev_entry = cell_entry[gi-1];
            end

            assign eq_vec[gi]  = cell_flag[gi].eq;
            // first larger key, or the first free slot when none is larger
            assign ins_vec[gi] = !prev_gt &&
                                 (cell_flag[gi].gt || (count_reg == CNT_W'(gi)));

            assign ctrl.cmp_en    = accept;
            assign ctrl.load_new  = commit && insert && ins_vec[gi];
            assign ctrl.load_prev = commit && insert && prev_gt;

            suki_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CNT_W'(gi)),
                .probe_key  (req.id_key),
                .new_entry  (hold_reg),
                .prev_entry (prev_entry),
                .entry      (cell_entry[gi]),
                .flag       (cell_flag[gi])
            );
        end
    endgenerate

    // one-hot to index
    always_comb
    begin
        slot_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_vec[i])
            begin
                slot_idx = slot_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        cmp_valid_next   = cmp_valid_reg;
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        position_next    = position_reg;
        entry_count_next = entry_count_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            cmp_valid_next = 1'b1;
        end
        else if (commit)
        begin
            cmp_valid_next = 1'b0;
        end

        if (commit)
        begin
            rsp_valid_next = 1'b1;
            position_next  = '0;
            priority if (full)
            begin
                status_next = ST_FULL;
            end
            else if (dup)
            begin
                status_next = ST_DUP;
            end
            else
            begin
                status_next   = ST_INSERTED;
                position_next = POS_W'(slot_idx);
                count_next    = count_reg + CNT_W'(1);
            end
            entry_count_next = ENTRY_CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= probe_entry;
        end
        status_reg      <= status_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
    end

    assign req.ready       = !cmp_valid_reg;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = entry_count_reg;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        (commit && insert) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

    a_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !(commit && insert) |=> (count_reg == $past(count_reg)))
        else $error("count moved without an insert");

    a_slot_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        (commit && insert) |-> $onehot(ins_vec))
        else $error("insertion slot not unique");
`endif
endmodule

// ----- hw/rtl/suki_cell.sv -----
module suki_cell (
    input  logic                clk,
    input  suki_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic [suki_pkg::KEY_W-1:0] probe_key,
    input  suki_pkg::entry_t    new_entry,
    input  suki_pkg::entry_t    prev_entry,
    output suki_pkg::entry_t    entry,
    output suki_pkg::cell_flag_t flag
);
    import suki_pkg::*;

    entry_t     entry_reg;
    entry_t     entry_next;
    cell_flag_t flag_reg;
    cell_flag_t flag_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.load_prev)
        begin
            entry_next = prev_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end

        flag_next = flag_reg;
        if (ctrl.cmp_en)
        begin
            flag_next.gt = occupied && (entry_reg.id_key > probe_key);
            flag_next.eq = occupied && (entry_reg.id_key == probe_key);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        flag_reg  <= flag_next;
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;
endmodule
